@@ src/olvd_pkg.sv @@
`default_nettype none
package olvd_pkg;

  // field widths fixed by the command and result formats
  localparam int MODE_W  = 3;
  localparam int WORD_W  = 32;
  localparam int COUNT_W = 6;

  // command modes
  localparam logic [MODE_W-1:0] MODE_APPEND    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_REM_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REM_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REM_VALUE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DUMP      = 3'd4;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     done_res;
    logic                     overflow;
    logic [COUNT_W-1:0]       count;
    logic signed [WORD_W-1:0] entry_value;
    logic                     is_empty;
    logic                     last;
  } res_t;

endpackage
`default_nettype wire

@@ src/olvd_ram.sv @@
`default_nettype none
module olvd_ram
  import olvd_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [AW-1:0]     waddr,
  input  wire logic [WORD_W-1:0] wdata,
  input  wire logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0]      rdata
);

  logic [WORD_W-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/ordered_list_with_value_delete.sv @@
`default_nettype none
// Ordered list of up to CAPACITY signed 32-bit words, front first.
// Command channel: cmd (mode, value) transfers on a rising edge with start
// high and busy low. Result channel: result is valid for exactly one cycle
// while result_strobe is high; the receiver takes it on that edge and cannot
// stall, so results are simply emitted in order.
// Command handling, with n the entry count before the command:
//   append, remove back, unused modes, commands on an empty list, and remove
//   front with n = 1: result in the cycle after the transfer, busy stays low,
//   one command per cycle.
//   remove front with n > 1: busy while the tail moves down one slot per
//   cycle, result in the cycle after the last move.
//   remove first match: busy while entries are scanned one per cycle up to
//   the match, then the entries behind it move down one per cycle.
//   dump: one entry result per cycle, last marked on the final one.
// The scan and the gap close both run through the single read port of the
// list memory, one entry per cycle; the scan uses one word compare.
// Reset empties the list; memory contents are not cleared, since only
// entries below the count are ever used.
module ordered_list_with_value_delete
  import olvd_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      result_strobe,
  output res_t      result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    SHIFT
  } state_t;

  state_t                   state;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            rd_idx;
  logic [AW-1:0]            chk_idx;
  logic [AW-1:0]            wr_idx;
  logic [MODE_W-1:0]        op_mode;
  logic signed [WORD_W-1:0] op_value;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  logic [CW-1:0] last_idx;
  logic [CW-1:0] sh_rd;
  logic          chk_last;
  logic          match;
  logic          accept;

  assign busy     = (state != IDLE);
  assign accept   = start && !busy;
  assign last_idx = cnt - CW'(1);
  assign sh_rd    = CW'(wr_idx) + CW'(2);
  assign chk_last = (CW'(chk_idx) == last_idx);
  // shared word compare for the value search
  assign match    = (mem_rdata == op_value);

  function automatic res_t status(input logic d, input logic ovf, input logic [CW-1:0] c);
    res_t r;
    r.done_res    = d;
    r.overflow    = ovf;
    r.count       = COUNT_W'(c);
    r.entry_value = '0;
    r.is_empty    = 1'b0;
    r.last        = 1'b1;
    return r;
  endfunction

  // single marker result for a dump of an empty list
  function automatic res_t empty_res();
    res_t r;
    r          = status(1'b0, 1'b0, '0);
    r.is_empty = 1'b1;
    return r;
  endfunction

  // one entry result of a dump burst
  function automatic res_t entry_res(input logic [WORD_W-1:0] v, input logic l,
                                     input logic [CW-1:0] c);
    res_t r;
    r             = status(1'b0, 1'b0, c);
    r.entry_value = v;
    r.last        = l;
    return r;
  endfunction

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = wr_idx;
    mem_wdata = mem_rdata;
    mem_raddr = '0;
    case (state)
      IDLE: begin
        if (cmd.mode == MODE_REM_FRONT) begin
          mem_raddr = AW'(1);
        end
        if (accept && cmd.mode == MODE_APPEND && cnt < CW'(CAPACITY)) begin
          mem_we    = 1'b1;
          mem_waddr = cnt[AW-1:0];
          mem_wdata = cmd.value;
        end
      end
      SCAN: begin
        mem_raddr = rd_idx[AW-1:0];
      end
      SHIFT: begin
        mem_we    = 1'b1;
        mem_raddr = sh_rd[AW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  olvd_ram #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      cnt           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            op_mode  <= cmd.mode;
            op_value <= cmd.value;
            rd_idx   <= CW'(1);
            chk_idx  <= '0;
            wr_idx   <= '0;
            case (cmd.mode)
              MODE_APPEND: begin
                result_strobe <= 1'b1;
                if (cnt < CW'(CAPACITY)) begin
                  cnt    <= cnt + CW'(1);
                  result <= status(1'b1, 1'b0, cnt + CW'(1));
                end else begin
                  result <= status(1'b0, 1'b1, cnt);
                end
              end
              MODE_REM_FRONT: begin
                if (cnt > CW'(1)) begin
                  state <= SHIFT;
                end else begin
                  result_strobe <= 1'b1;
                  cnt           <= '0;
                  result        <= status(cnt != '0, 1'b0, '0);
                end
              end
              MODE_REM_BACK: begin
                result_strobe <= 1'b1;
                if (cnt != '0) begin
                  cnt    <= last_idx;
                  result <= status(1'b1, 1'b0, last_idx);
                end else begin
                  result <= status(1'b0, 1'b0, cnt);
                end
              end
              MODE_REM_VALUE: begin
                if (cnt != '0) begin
                  state <= SCAN;
                end else begin
                  result_strobe <= 1'b1;
                  result        <= status(1'b0, 1'b0, cnt);
                end
              end
              MODE_DUMP: begin
                if (cnt != '0) begin
                  state <= SCAN;
                end else begin
                  result_strobe <= 1'b1;
                  result        <= empty_res();
                end
              end
              default: begin
                result_strobe <= 1'b1;
                result        <= status(1'b0, 1'b0, cnt);
              end
            endcase
          end
        end
        SCAN: begin
          rd_idx <= rd_idx + CW'(1);
          if (op_mode == MODE_DUMP) begin
            // emit the entry read last cycle
            result_strobe <= 1'b1;
            result        <= entry_res(mem_rdata, chk_last, cnt);
            if (chk_last) begin
              state <= IDLE;
            end else begin
              chk_idx <= chk_idx + AW'(1);
            end
          end else if (match) begin
            if (chk_last) begin
              result_strobe <= 1'b1;
              cnt           <= last_idx;
              result        <= status(1'b1, 1'b0, last_idx);
              state         <= IDLE;
            end else begin
              // the next entry is already being read: close the gap from here
              wr_idx <= chk_idx;
              state  <= SHIFT;
            end
          end else if (chk_last) begin
            result_strobe <= 1'b1;
            result        <= status(1'b0, 1'b0, cnt);
            state         <= IDLE;
          end else begin
            chk_idx <= chk_idx + AW'(1);
          end
        end
        SHIFT: begin
          // entry wr_idx+1 moves into wr_idx
          if (sh_rd == cnt) begin
            result_strobe <= 1'b1;
            cnt           <= last_idx;
            result        <= status(1'b1, 1'b0, last_idx);
            state         <= IDLE;
          end else begin
            wr_idx <= wr_idx + AW'(1);
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // checks on the sequencer
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_dump_burst: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last |=> result_strobe)
    else $error("dump burst broken before last entry");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.is_empty |-> result.last && result.count == '0)
    else $error("empty marker without last or with nonzero count");

  a_ovf_full: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.overflow |-> cnt == CW'(CAPACITY) && !result.done_res)
    else $error("overflow reported on a list that is not full");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == SHIFT |-> CW'(wr_idx) + CW'(2) <= cnt)
    else $error("gap close past the end of the list");

endmodule
`default_nettype wire

@@ tb/ordered_list_with_value_delete_tb.sv @@
`default_nettype none
module ordered_list_with_value_delete_tb;
  import olvd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 32;
  localparam int RANDOM_ITEMS = 448;
  localparam int QUIET_TAIL   = 80;
  localparam int PHASE_LEN    = 60;
  localparam int CYCLE_LIMIT  = 200000;

  // spare mode codes, no operation behind them
  localparam logic [MODE_W-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_7 = 3'd7;

  // random phases, each biased toward one kind of traffic
  localparam int PHASE_FILL  = 0;
  localparam int PHASE_MIXED = 1;
  localparam int PHASE_DRAIN = 2;

  // shadow list plus the results it predicts
  class list_scoreboard;
    logic signed [WORD_W-1:0] words[$];
    res_t expected_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // random word currently stored, or any word when the list is empty
    function logic signed [WORD_W-1:0] pick_stored();
      if (words.size() == 0) return $urandom;
      return words[$urandom_range(0, words.size() - 1)];
    endfunction

    // apply an accepted command to the shadow list and queue its results
    function void record_cmd(cmd_t c);
      res_t r;
      int n;
      int hit;
      r = '0;
      r.last = 1'b1;
      case (c.mode)
        MODE_APPEND: begin
          if (words.size() < CAPACITY) begin
            words.push_back(c.value);
            r.done_res = 1'b1;
          end else begin
            r.overflow = 1'b1;
          end
        end
        MODE_REM_FRONT: begin
          if (words.size() > 0) begin
            void'(words.pop_front());
            r.done_res = 1'b1;
          end
        end
        MODE_REM_BACK: begin
          if (words.size() > 0) begin
            void'(words.pop_back());
            r.done_res = 1'b1;
          end
        end
        MODE_REM_VALUE: begin
          hit = -1;
          for (int i = 0; i < words.size(); i++) begin
            if (hit < 0 && words[i] == c.value) hit = i;
          end
          if (hit >= 0) begin
            words.delete(hit);
            r.done_res = 1'b1;
          end
        end
        MODE_DUMP: begin
          n = words.size();
          if (n == 0) begin
            r.is_empty = 1'b1;
            expected_results.push_back(r);
          end
          for (int i = 0; i < n; i++) begin
            r = '0;
            r.count = COUNT_W'(n);
            r.entry_value = words[i];
            r.last = (i == n - 1);
            expected_results.push_back(r);
          end
          return;
        end
        default: ;
      endcase
      r.count = COUNT_W'(words.size());
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [WORD_W-1:0] want,
                              logic [WORD_W-1:0] got, time stamp);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", stamp, name, want, got);
      end
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(res_t got, time stamp);
      res_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", stamp, got);
        return;
      end
      want = expected_results.pop_front();
      check_field("done_res", WORD_W'(want.done_res), WORD_W'(got.done_res), stamp);
      check_field("overflow", WORD_W'(want.overflow), WORD_W'(got.overflow), stamp);
      check_field("count", WORD_W'(want.count), WORD_W'(got.count), stamp);
      check_field("entry_value", want.entry_value, got.entry_value, stamp);
      check_field("is_empty", WORD_W'(want.is_empty), WORD_W'(got.is_empty), stamp);
      check_field("last", WORD_W'(want.last), WORD_W'(got.last), stamp);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic result_strobe;
  res_t result;
  int unsigned cycles = 0;

  list_scoreboard sb = new();

  ordered_list_with_value_delete #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .cmd(cmd),
    .busy(busy),
    .result_strobe(result_strobe),
    .result(result)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result monitor, receiver never stalls
  always @(posedge clk) begin
    if (!rst && result_strobe) sb.check_result(result, $time);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("ordered_list_with_value_delete_tb: done, errors");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(logic [MODE_W-1:0] mode, logic signed [WORD_W-1:0] value);
    cmd_t c;
    c.mode = mode;
    c.value = value;
    return c;
  endfunction

  // small words repeat often, so searches hit and duplicates appear
  function automatic logic signed [WORD_W-1:0] small_word();
    logic signed [WORD_W-1:0] v;
    v = $urandom_range(0, 8);
    return v - 4;
  endfunction

  function automatic logic signed [WORD_W-1:0] append_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return small_word();
    if (pick < 58) return {1'b1, {(WORD_W - 1){1'b0}}};
    if (pick < 66) return {1'b0, {(WORD_W - 1){1'b1}}};
    return $urandom;
  endfunction

  function automatic cmd_t next_random_cmd(int phase);
    int unsigned r;
    logic signed [WORD_W-1:0] key;
    r = $urandom_range(0, 99);
    // remap the draw so each phase gets its own mix
    if (phase == PHASE_FILL) begin
      if (r < 78) return make_cmd(MODE_APPEND, append_word());
      r = 80 + (r - 78) * 20 / 22;
    end else if (phase == PHASE_DRAIN) begin
      if (r < 14) return make_cmd(MODE_APPEND, append_word());
      r = 40 + (r - 14) * 60 / 86;
    end else if (phase == PHASE_MIXED) begin
      if (r < 40) return make_cmd(MODE_APPEND, append_word());
    end
    // r now lies in 40..99
    if (r < 62) begin
      key = ($urandom_range(0, 4) < 3) ? sb.pick_stored()
          : ($urandom_range(0, 1) != 0) ? small_word() : WORD_W'($urandom);
      return make_cmd(MODE_REM_VALUE, key);
    end
    if (r < 74) return make_cmd(MODE_REM_FRONT, $urandom);
    if (r < 86) return make_cmd(MODE_REM_BACK, $urandom);
    if (r < 96) return make_cmd(MODE_DUMP, $urandom);
    return make_cmd(MODE_SPARE_5 + MODE_W'($urandom_range(0, 2)), $urandom);
  endfunction

  // hold a command until it transfers
  task automatic send(cmd_t c);
    @(negedge clk);
    start <= 1'b1;
    cmd <= c;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.record_cmd(c);
  endtask

  // sender gap, with junk on the command bus
  task automatic idle(int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
      cmd <= {MODE_W'($urandom), WORD_W'($urandom)};
    end
  endtask

  task automatic wait_drained();
    idle(1);
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int phase;
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty list corners and spare modes
    send(make_cmd(MODE_DUMP, 0));
    send(make_cmd(MODE_REM_FRONT, 0));
    send(make_cmd(MODE_REM_BACK, -1));
    send(make_cmd(MODE_REM_VALUE, 0));
    send(make_cmd(MODE_SPARE_5, $urandom));
    send(make_cmd(MODE_SPARE_6, $urandom));
    send(make_cmd(MODE_SPARE_7, $urandom));
    // extremes, duplicates, then searches at front, middle, tail and a miss
    send(make_cmd(MODE_APPEND, 32'sh7fffffff));
    send(make_cmd(MODE_APPEND, 32'sh80000000));
    send(make_cmd(MODE_APPEND, 0));
    send(make_cmd(MODE_APPEND, -1));
    send(make_cmd(MODE_APPEND, 0));
    send(make_cmd(MODE_APPEND, 5));
    send(make_cmd(MODE_DUMP, -1));
    send(make_cmd(MODE_REM_VALUE, 0));
    send(make_cmd(MODE_REM_VALUE, 99));
    send(make_cmd(MODE_REM_VALUE, 32'sh7fffffff));
    send(make_cmd(MODE_REM_VALUE, 5));
    send(make_cmd(MODE_DUMP, 0));
    send(make_cmd(MODE_REM_FRONT, 0));
    send(make_cmd(MODE_SPARE_6, -1));
    send(make_cmd(MODE_REM_BACK, 0));
    send(make_cmd(MODE_DUMP, 0));
    wait_drained();

    // random traffic, fill / mixed / drain phases in rotation
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      phase = (k / PHASE_LEN) % 3;
      if (k > 0 && k % 100 == 0 && k < RANDOM_ITEMS - QUIET_TAIL) wait_drained();
      if (k < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(0, 99) < 30)
        idle($urandom_range(1, 12));
      send(next_random_cmd(phase));
    end

    // let the tail of the work drain, then settle
    wait_drained();
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (sb.pending() > 0)
      $display("%0t: %0d expected results never arrived", $time, sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ordered_list_with_value_delete_tb: done, clean");
    end else begin
      $display("ordered_list_with_value_delete_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
